// File: hw/rtl/sir_rk4_pkg.sv
// Shared types and constants for the SIR fourth-order Runge-Kutta stepper
// Used by the divider, the top level and the testbench; no dependencies
`timescale 1ns / 1ps

package sir_rk4_pkg;

  // value format and divider sizes
  localparam int unsigned VAL_W  = 40;
  localparam int unsigned DIV_W  = 24;
  localparam int unsigned DQ_W   = 64;
  localparam int unsigned CNT_W  = 6;

  localparam logic [VAL_W-1:0] MAX_VAL = '1;

  // configuration register indexes
  localparam logic [1:0] REG_INFECTION = 2'd0;
  localparam logic [1:0] REG_RECOVERY  = 2'd1;
  localparam logic [1:0] REG_POP       = 2'd2;
  localparam logic [1:0] REG_STEP      = 2'd3;

  // iteration count of the shared divider
  localparam logic [CNT_W-1:0] DIV_CNT_POP = 6'd40;

  // division by six, 11 bits per step: floor(y/6) = (y * RECIP_SIX) >> 17
  // holds for every y below 2^15
  localparam logic [14:0] RECIP_SIX = 15'd21846;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
  } div_req_t;

endpackage

// File: hw/rtl/sir_rk4_div.sv
// Bit-serial restoring divider, one quotient bit per cycle
// Depends on sir_rk4_pkg
`timescale 1ns / 1ps

module sir_rk4_div (
  input  logic                         clk,
  input  logic                         rst,
  input  sir_rk4_pkg::div_req_t        req,
  input  logic [sir_rk4_pkg::DIV_W-1:0] rem_init,
  input  logic [sir_rk4_pkg::DQ_W-1:0]  dq_init,
  input  logic [sir_rk4_pkg::DIV_W-1:0] divisor,
  output logic                         done,
  output logic [sir_rk4_pkg::DQ_W-1:0]  dq
);
  import sir_rk4_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   partial;
  logic [DIV_W:0]   diff;
  logic             ge;
  logic [DIV_W-1:0] rem_next;

  // one trial subtraction
  always_comb begin
    partial  = {rem, dq[DQ_W-1]};
    diff     = partial - {1'b0, dvs};
    ge       = partial >= {1'b0, dvs};
    rem_next = ge ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= rem_init;
      dq  <= dq_init;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= {dq[DQ_W-2:0], ge};
    end
  end

endmodule

// File: hw/rtl/sir_epidemic_rk4_step.sv
// Top level of the SIR epidemic integrator, one RK4 step per input word
// Depends on sir_rk4_pkg and sir_rk4_div
`timescale 1ns / 1ps

// Each accepted input word advances S, I and R (unsigned Q24.16) by one
// classical fourth-order Runge-Kutta step and produces one output word with
// the new triple; restart reloads S=N-1, I=1, R=0 first. Results below zero
// or above the 40-bit range saturate. Each word runs four slope evaluations,
// each with the division by N in the bit-serial divider (one quotient bit
// per cycle, 40 bits; a saturating quotient skips it), then three divisions
// by six for the weighted average, 11 bits per cycle by reciprocal
// multiplication, and last the load of the output register. A single 40x20
// multiplier serves every product of the slope evaluations. The input stalls
// from acceptance until the result is placed in the output register; a result
// waiting there does not block the next word, but the word after that waits
// for it.
module sir_epidemic_rk4_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [39:0] susceptible,
  output logic [39:0] infected,
  output logic [39:0] recovered
);
  import sir_rk4_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POINT, ST_SI_LO, ST_SI_HI, ST_SI_SUM, ST_DIVN, ST_DIVN_WAIT,
    ST_BETA, ST_GAMMA, ST_H_INF, ST_H_REC, ST_SLOPE, ST_FIN_START,
    ST_FIN_WAIT, ST_FIN_APPLY, ST_OUT
  } state_t;

  localparam logic [1:0] FIN_S = 2'd0;
  localparam logic [1:0] FIN_I = 2'd1;
  localparam logic [1:0] FIN_R = 2'd2;

  state_t state;

  logic [19:0] infection_rate;
  logic [19:0] recovery_rate;
  logic [23:0] population;
  logic [15:0] step_size;

  logic [VAL_W-1:0] s_level, i_level, r_level;
  logic [1:0]       stage;
  logic [1:0]       fin_idx;
  logic             fin_neg;

  logic [VAL_W-1:0] ps, pi, u_val, inf_val, rec_val, kinf, krec;
  logic [79:0]      pacc;
  logic [42:0]      acc_inf, acc_rec;
  logic [59:0]      prod;
  logic [39:0]      mul_a;
  logic [19:0]      mul_b;

  logic [DIV_W-1:0] n_div;
  logic             n_sat;
  div_req_t         div_req;
  logic [DIV_W-1:0] div_rem_init, div_divisor;
  logic [DQ_W-1:0]  div_dq_init, div_q;
  logic             div_done;

  logic signed [42:0] ks_k, ki_k, ks_adj, ki_adj;
  logic signed [43:0] ps_sum, pi_sum;
  logic [VAL_W-1:0]   ps_next, pi_next;
  logic signed [44:0] fin_v, fin_mag_s, fin_delta;
  logic [43:0]        fin_mag;
  logic [VAL_W-1:0]   fin_old, fin_new;
  logic signed [45:0] fin_sum;
  logic [42:0]        kinf_w, krec_w;
  logic [VAL_W-1:0]   krec_new;

  logic [43:0]        fin_x;
  logic [2:0]         fin_rem;
  logic [1:0]         fin_cnt;
  logic [13:0]        d6_y;
  logic [28:0]        d6_prod;
  logic [10:0]        d6_q;
  logic [13:0]        d6_r;

  function automatic logic [VAL_W-1:0] clamp44(input logic signed [43:0] v);
    if (v[43]) begin
      return '0;
    end else if (|v[42:40]) begin
      return MAX_VAL;
    end
    return v[39:0];
  endfunction

  function automatic logic [VAL_W-1:0] clamp46(input logic signed [45:0] v);
    if (v[45]) begin
      return '0;
    end else if (|v[44:40]) begin
      return MAX_VAL;
    end
    return v[39:0];
  endfunction

  function automatic logic [VAL_W-1:0] scale_sat(input logic [59:0] p);
    return (|p[59:56]) ? MAX_VAL : p[55:16];
  endfunction

  assign in_stall = (state != ST_IDLE);
  assign n_div    = (population == '0) ? DIV_W'(1) : population;
  assign n_sat    = pacc[79:56] >= n_div;
  assign krec_new = prod[55:16];

  // stage point from the previous slope
  always_comb begin
    ks_k = -$signed({3'b0, kinf});
    ki_k = $signed({3'b0, kinf}) - $signed({3'b0, krec});
    case (stage)
      2'd0: begin
        ks_adj = '0;
        ki_adj = '0;
      end
      2'd3: begin
        ks_adj = ks_k;
        ki_adj = ki_k;
      end
      default: begin
        ks_adj = ks_k >>> 1;
        ki_adj = ki_k >>> 1;
      end
    endcase
    ps_sum  = $signed({4'b0, s_level}) + {ks_adj[42], ks_adj};
    pi_sum  = $signed({4'b0, i_level}) + {ki_adj[42], ki_adj};
    ps_next = clamp44(ps_sum);
    pi_next = clamp44(pi_sum);
  end

  // weighted slope sums folded into one compartment value
  always_comb begin
    case (fin_idx)
      FIN_S: begin
        fin_v   = -$signed({2'b0, acc_inf});
        fin_old = s_level;
      end
      FIN_I: begin
        fin_v   = $signed({2'b0, acc_inf}) - $signed({2'b0, acc_rec});
        fin_old = i_level;
      end
      default: begin
        fin_v   = $signed({2'b0, acc_rec});
        fin_old = r_level;
      end
    endcase
    fin_mag_s = fin_v[44] ? (-fin_v + 45'sd5) : fin_v;
    fin_mag   = fin_mag_s[43:0];
    fin_delta = fin_neg ? -$signed({1'b0, fin_x}) : $signed({1'b0, fin_x});
    fin_sum   = $signed({6'b0, fin_old}) + {fin_delta[44], fin_delta};
    fin_new   = clamp46(fin_sum);
  end

  // one 11-bit step of the division by six
  always_comb begin
    d6_y    = {fin_rem, fin_x[43:33]};
    d6_prod = 29'(d6_y) * 29'(RECIP_SIX);
    d6_q    = d6_prod[27:17];
    d6_r    = d6_y - 14'(d6_q) * 14'd6;
  end

  // slope weights: 1, 2, 2, 1
  always_comb begin
    if (stage == 2'd1 || stage == 2'd2) begin
      kinf_w = {2'b0, kinf, 1'b0};
      krec_w = {2'b0, krec_new, 1'b0};
    end else begin
      kinf_w = {3'b0, kinf};
      krec_w = {3'b0, krec_new};
    end
  end

  // shared multiplier operand selection
  always_comb begin
    case (state)
      ST_SI_LO: begin
        mul_a = ps;
        mul_b = pi[19:0];
      end
      ST_SI_HI: begin
        mul_a = ps;
        mul_b = pi[39:20];
      end
      ST_BETA: begin
        mul_a = u_val;
        mul_b = infection_rate;
      end
      ST_GAMMA: begin
        mul_a = pi;
        mul_b = recovery_rate;
      end
      ST_H_INF: begin
        mul_a = inf_val;
        mul_b = {4'b0, step_size};
      end
      ST_H_REC: begin
        mul_a = rec_val;
        mul_b = {4'b0, step_size};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider requests
  always_comb begin
    div_req.start = (state == ST_DIVN) && !n_sat;
    div_req.count = DIV_CNT_POP;
    div_rem_init  = pacc[79:56];
    div_dq_init   = {pacc[55:16], 24'b0};
    div_divisor   = n_div;
  end

  sir_rk4_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .rem_init (div_rem_init),
    .dq_init  (div_dq_init),
    .divisor  (div_divisor),
    .done     (div_done),
    .dq       (div_q)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_POINT: begin
        ps <= ps_next;
        pi <= pi_next;
      end
      ST_SI_HI:  pacc <= {20'b0, prod};
      ST_SI_SUM: pacc <= pacc + {prod, 20'b0};
      ST_DIVN: begin
        if (n_sat) begin
          u_val <= MAX_VAL;
        end
      end
      ST_DIVN_WAIT: begin
        if (div_done) begin
          u_val <= div_q[39:0];
        end
      end
      ST_GAMMA: inf_val <= scale_sat(prod);
      ST_H_INF: rec_val <= scale_sat(prod);
      ST_H_REC: kinf <= prod[55:16];
      ST_SLOPE: krec <= krec_new;
      ST_FIN_START: begin
        fin_neg <= fin_v[44];
        fin_x   <= fin_mag;
        fin_rem <= '0;
        fin_cnt <= '0;
      end
      ST_FIN_WAIT: begin
        fin_x   <= {fin_x[32:0], d6_q};
        fin_rem <= d6_r[2:0];
        fin_cnt <= fin_cnt + 2'd1;
      end
      default: ;
    endcase
  end

  // sequencer, configuration, levels and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      stage          <= '0;
      fin_idx        <= FIN_S;
      acc_inf        <= '0;
      acc_rec        <= '0;
      infection_rate <= 20'd65536;
      recovery_rate  <= 20'd6554;
      population     <= 24'd1000;
      step_size      <= 16'd6554;
      s_level        <= VAL_W'(999) << 16;
      i_level        <= VAL_W'(1) << 16;
      r_level        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INFECTION: infection_rate <= cfg_data[19:0];
          REG_RECOVERY:  recovery_rate  <= cfg_data[19:0];
          REG_POP:       population     <= cfg_data;
          REG_STEP:      step_size      <= cfg_data[15:0];
          default: ;
        endcase
      end
      // output word handshake
      if (state == ST_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (restart) begin
              s_level <= (population == '0) ? '0 : {population - 24'd1, 16'b0};
              i_level <= VAL_W'(1) << 16;
              r_level <= '0;
            end
            stage   <= '0;
            acc_inf <= '0;
            acc_rec <= '0;
            state   <= ST_POINT;
          end
        end
        ST_POINT:  state <= ST_SI_LO;
        ST_SI_LO:  state <= ST_SI_HI;
        ST_SI_HI:  state <= ST_SI_SUM;
        ST_SI_SUM: state <= ST_DIVN;
        ST_DIVN:   state <= n_sat ? ST_BETA : ST_DIVN_WAIT;
        ST_DIVN_WAIT: begin
          if (div_done) begin
            state <= ST_BETA;
          end
        end
        ST_BETA:  state <= ST_GAMMA;
        ST_GAMMA: state <= ST_H_INF;
        ST_H_INF: state <= ST_H_REC;
        ST_H_REC: state <= ST_SLOPE;
        ST_SLOPE: begin
          acc_inf <= acc_inf + kinf_w;
          acc_rec <= acc_rec + krec_w;
          stage   <= stage + 2'd1;
          if (stage == 2'd3) begin
            fin_idx <= FIN_S;
            state   <= ST_FIN_START;
          end else begin
            state <= ST_POINT;
          end
        end
        ST_FIN_START: state <= ST_FIN_WAIT;
        ST_FIN_WAIT: begin
          if (fin_cnt == 2'd3) begin
            state <= ST_FIN_APPLY;
          end
        end
        ST_FIN_APPLY: begin
          case (fin_idx)
            FIN_S:   s_level <= fin_new;
            FIN_I:   i_level <= fin_new;
            default: r_level <= fin_new;
          endcase
          if (fin_idx == FIN_R) begin
            state <= ST_OUT;
          end else begin
            fin_idx <= fin_idx + 2'd1;
            state   <= ST_FIN_START;
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            susceptible <= s_level;
            infected    <= i_level;
            recovered   <= r_level;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/sir_rk4_checker.sv
// Port-level checks for the SIR RK4 stepper, bound to the top level
// Depends on the top level's ports only
`timescale 1ns / 1ps

module sir_rk4_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [39:0] susceptible,
  input logic [39:0] infected,
  input logic [39:0] recovered
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(susceptible) && $stable(infected)
      && $stable(recovered))
    else $error("result payload changed while stalled");

  // an accepted word keeps the input stalled while it is worked on
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after acceptance");

  // a new result only appears at the end of a busy period
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without a word in progress");

endmodule

bind sir_epidemic_rk4_step sir_rk4_checker u_sir_rk4_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for sir_epidemic_rk4_step: directed table, then random ticks
// Depends on sir_rk4_pkg and the RTL of the stepper; predicts every output word itself
`timescale 1ns / 1ps

module tb_top;
  import sir_rk4_pkg::*;

  localparam int unsigned RAND_TICKS = 600;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct {
    logic [VAL_W-1:0] s;
    logic [VAL_W-1:0] i;
    logic [VAL_W-1:0] r;
  } sir_word_t;

  typedef struct {
    logic [23:0] beta;
    logic [23:0] gamma;
    logic [23:0] pop;
    logic [23:0] h;
    bit          rs;
    bit          typed;
    sir_word_t   want;
  } tick_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_INFECTION;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [39:0] susceptible;
  logic [39:0] infected;
  logic [39:0] recovered;

  // predictor copy of configuration and compartments
  logic [19:0] beta_q;
  logic [19:0] gamma_q;
  logic [23:0] pop_n;
  logic [15:0] h_q;
  logic [VAL_W-1:0] lvl_s;
  logic [VAL_W-1:0] lvl_i;
  logic [VAL_W-1:0] lvl_r;

  sir_word_t   sir_due_q[$];
  sir_word_t   typed_due_q[$];
  bit          typed_flag_q[$];
  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned words_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;
  int unsigned stall_left = 0;

  sir_epidemic_rk4_step u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .susceptible(susceptible), .infected(infected), .recovered(recovered)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("FAIL sir_epidemic_rk4_step");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] clamp_val(longint v);
    if (v < 0) return '0;
    if (v > longint'({24'd0, MAX_VAL})) return MAX_VAL;
    return v[VAL_W-1:0];
  endfunction

  function automatic longint floor_by(longint v, longint d);
    if (v >= 0) return v / d;
    return -((-v + d - 1) / d);
  endfunction

  function automatic logic [VAL_W-1:0] sat64(logic [63:0] v);
    return (v > {24'd0, MAX_VAL}) ? MAX_VAL : v[VAL_W-1:0];
  endfunction

  // one derivative evaluation scaled by h
  task automatic slope(input logic [VAL_W-1:0] s, input logic [VAL_W-1:0] i,
                       output longint ks, output longint ki, output longint kr);
    logic [79:0] prod;
    logic [79:0] quo;
    logic [23:0] n;
    logic [63:0] u;
    logic [63:0] infl;
    logic [63:0] recl;
    longint      kinf;
    longint      krec;
    n = (pop_n == 0) ? 24'd1 : pop_n;
    prod = {40'd0, s} * {40'd0, i};
    quo = (prod / {56'd0, n}) >> 16;
    u = (quo > {40'd0, MAX_VAL}) ? {24'd0, MAX_VAL} : quo[63:0];
    infl = {24'd0, sat64(({44'd0, beta_q} * u) >> 16)};
    recl = {24'd0, sat64(({44'd0, gamma_q} * {24'd0, i}) >> 16)};
    kinf = longint'(({48'd0, h_q} * infl) >> 16);
    krec = longint'(({48'd0, h_q} * recl) >> 16);
    ks = -kinf;
    ki = kinf - krec;
    kr = krec;
  endtask

  // one rk4 tick of the predictor
  task automatic rk4_tick(input bit rs, output sir_word_t w);
    longint s1, i1, r1, s2, i2, r2, s3, i3, r3, s4, i4, r4;
    if (rs) begin
      lvl_s = (pop_n == 0) ? '0 : {16'd0, pop_n - 24'd1} << 16;
      lvl_i = 40'd65536;
      lvl_r = '0;
    end
    slope(lvl_s, lvl_i, s1, i1, r1);
    slope(clamp_val(longint'(lvl_s) + floor_by(s1, 2)),
          clamp_val(longint'(lvl_i) + floor_by(i1, 2)), s2, i2, r2);
    slope(clamp_val(longint'(lvl_s) + floor_by(s2, 2)),
          clamp_val(longint'(lvl_i) + floor_by(i2, 2)), s3, i3, r3);
    slope(clamp_val(longint'(lvl_s) + s3), clamp_val(longint'(lvl_i) + i3), s4, i4, r4);
    lvl_s = clamp_val(longint'(lvl_s) + floor_by(s1 + 2 * s2 + 2 * s3 + s4, 6));
    lvl_i = clamp_val(longint'(lvl_i) + floor_by(i1 + 2 * i2 + 2 * i3 + i4, 6));
    lvl_r = clamp_val(longint'(lvl_r) + floor_by(r1 + 2 * r2 + 2 * r3 + r4, 6));
    w.s = lvl_s;
    w.i = lvl_i;
    w.r = lvl_r;
  endtask

  // register write; block must be idle
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    case (idx)
      REG_INFECTION: beta_q = val[19:0];
      REG_RECOVERY:  gamma_q = val[19:0];
      REG_POP:       pop_n = val;
      REG_STEP:      h_q = val[15:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_rates(input logic [23:0] b, input logic [23:0] g,
                           input logic [23:0] p, input logic [23:0] h);
    in_valid = 1'b0;
    wait (sir_due_q.size() == 0);
    repeat (8) @(negedge clk);
    write_reg(REG_INFECTION, b);
    write_reg(REG_RECOVERY, g);
    write_reg(REG_POP, p);
    write_reg(REG_STEP, h);
  endtask

  // send one tick word, optionally with a typed expectation
  task automatic send_tick(input bit rs, input bit typed, input sir_word_t want);
    sir_word_t w;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid = 1'b1;
    restart = rs;
    do @(posedge clk); while (in_stall);
    rk4_tick(rs, w);
    sir_due_q.push_back(w);
    typed_flag_q.push_back(typed);
    typed_due_q.push_back(want);
    ticks_sent++;
    @(negedge clk);
  endtask

  // output stall in random bursts
  always @(negedge clk) begin
    if (quiet || rst) begin
      out_stall = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_stall = 1'b0;
    end
  end

  // compare each accepted output word with the oldest prediction
  always @(posedge clk) begin
    sir_word_t e;
    sir_word_t t;
    bit        tf;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (sir_due_q.size() == 0) begin
        $display("%0t unexpected word s=%0h i=%0h r=%0h", $time,
                 susceptible, infected, recovered);
        errors++;
      end else begin
        e = sir_due_q.pop_front();
        t = typed_due_q.pop_front();
        tf = typed_flag_q.pop_front();
        // hand-typed rows must also agree with the predictor
        if (tf && (t.s !== e.s || t.i !== e.i || t.r !== e.r)) begin
          $display("%0t typed row disagrees with predictor: s=%0h i=%0h r=%0h",
                   $time, t.s, t.i, t.r);
          errors++;
        end
        if (susceptible !== e.s) begin
          $display("%0t susceptible: expected %0h actual %0h", $time, e.s, susceptible);
          errors++;
        end
        if (infected !== e.i) begin
          $display("%0t infected: expected %0h actual %0h", $time, e.i, infected);
          errors++;
        end
        if (recovered !== e.r) begin
          $display("%0t recovered: expected %0h actual %0h", $time, e.r, recovered);
          errors++;
        end
      end
    end
  end

  function automatic logic [23:0] pick(logic [23:0] lo, logic [23:0] hi, int unsigned w);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return 24'($urandom() & ((1 << w) - 1));
    endcase
  endfunction

  initial begin
    tick_row_t   rows[$];
    tick_row_t   row;
    sir_word_t   none;
    logic [23:0] cb, cg, cp, ch;
    int unsigned phase_len;
    int unsigned sent_rand;
    none = '{s: '0, i: '0, r: '0};
    beta_q = 20'd65536;
    gamma_q = 20'd6554;
    pop_n = 24'd1000;
    h_q = 16'd6554;
    lvl_s = 40'd999 << 16;
    lvl_i = 40'd65536;
    lvl_r = '0;

    // directed table: beta, gamma, N, h, restart, typed, expected
    rows.push_back('{24'd65536, 24'd6554, 24'd1000, 24'd6554, 0, 0, none});
    rows.push_back('{24'd65536, 24'd6554, 24'd1000, 24'd6554, 1, 0, none});
    rows.push_back('{24'd65536, 24'd6554, 24'd1000, 24'd6554, 0, 0, none});
    // zero step size leaves the reloaded state alone
    rows.push_back('{24'd65536, 24'd6554, 24'd1000, 24'd0, 1, 1,
                     '{40'd999 << 16, 40'd65536, 40'd0}});
    rows.push_back('{24'd65536, 24'd6554, 24'd1000, 24'd0, 0, 1,
                     '{40'd999 << 16, 40'd65536, 40'd0}});
    // population zero reloads an empty susceptible pool
    rows.push_back('{24'd65536, 24'd6554, 24'd0, 24'd0, 1, 1, '{40'd0, 40'd65536, 40'd0}});
    rows.push_back('{24'd65536, 24'd6554, 24'd0, 24'd6554, 0, 0, none});
    rows.push_back('{24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'hFFFF, 0, 0, none});
    // fastest growth: N of one, largest infection rate and step, no recovery
    rows.push_back('{24'hFFFFFF, 24'd0, 24'd1, 24'hFFFF, 1, 0, none});
    for (int k = 0; k < 5; k++)
      rows.push_back('{24'hFFFFFF, 24'd0, 24'd1, 24'hFFFF, 0, 0, none});
    rows.push_back('{24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFF, 1, 0, none});
    rows.push_back('{24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFF, 0, 0, none});
    rows.push_back('{24'd0, 24'd0, 24'hFFFFFF, 24'hFFFF, 0, 0, none});
    rows.push_back('{24'hFFFFF, 24'hFFFFF, 24'hFFFFFF, 24'd1, 1, 0, none});
    rows.push_back('{24'hFFFFF, 24'hFFFFF, 24'hFFFFFF, 24'd1, 0, 0, none});
    rows.push_back('{24'h5A5A5A, 24'hA5A5A5, 24'hAAAAAA, 24'h555555, 1, 0, none});
    rows.push_back('{24'h5A5A5A, 24'hA5A5A5, 24'hAAAAAA, 24'h555555, 0, 0, none});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    cb = 24'd65536;
    cg = 24'd6554;
    cp = 24'd1000;
    ch = 24'd6554;
    foreach (rows[k]) begin
      row = rows[k];
      if (row.beta != cb || row.gamma != cg || row.pop != cp || row.h != ch) begin
        cb = row.beta;
        cg = row.gamma;
        cp = row.pop;
        ch = row.h;
        set_rates(cb, cg, cp, ch);
      end
      send_tick(row.rs, row.typed, row.want);
    end

    // random phases, each with its own rates
    sent_rand = 0;
    while (sent_rand < RAND_TICKS) begin
      cb = pick(24'd0, 24'hFFFFFF, 24);
      cg = pick(24'd0, 24'hFFFFFF, 24);
      cp = ($urandom_range(0, 9) == 0) ? 24'd0 : pick(24'd1, 24'hFFFFFF, 24);
      if ($urandom_range(0, 1) == 0) cp = 24'($urandom_range(1, 5000));
      ch = pick(24'd1, 24'hFFFF, 24);
      if ($urandom_range(0, 15) == 0) ch = 24'd0;
      set_rates(cb, cg, cp, ch);
      quiet = (sent_rand + 100 >= RAND_TICKS) || ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(20, 60);
      for (int k = 0; k < phase_len; k++) begin
        send_tick((k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0),
                  0, none);
        sent_rand++;
      end
    end
    in_valid = 1'b0;
    quiet = 1'b1;

    wait (sir_due_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sir_due_q.size() != 0) begin
      $display("%0t %0d predicted words never arrived", $time, sir_due_q.size());
      errors++;
    end
    $display("ran %0d ticks, checked %0d output words over %0d register writes",
             ticks_sent, words_seen, cfg_writes);
    $display("covered restarts, zero population and step, saturating rates, random stalls");
    if (errors == 0) begin
      $display("PASS sir_epidemic_rk4_step");
    end else begin
      $display("FAIL sir_epidemic_rk4_step");
    end
    $finish;
  end

endmodule
